/* rtl/sfjc_pkg.sv */
// Shared types and constants for the shooter feed and jam controller.
// No dependencies.
`timescale 1ns / 1ps
package sfjc_pkg;
  localparam int unsigned CfgAddrW = 5;
  localparam logic [16:0] FullTurn = 17'd92160;
  localparam logic [15:0] HalfTurn = 16'd46080;
  localparam logic [15:0] ShotWrap = 16'd60000;

  localparam logic [CfgAddrW-1:0] AddrMargin = 5'h00;
  localparam logic [CfgAddrW-1:0] AddrStall  = 5'h04;
  localparam logic [CfgAddrW-1:0] AddrBack   = 5'h08;
  localparam logic [CfgAddrW-1:0] AddrStep   = 5'h0C;
  localparam logic [CfgAddrW-1:0] AddrPeriod = 5'h10;

  localparam logic [1:0] SwNone = 2'd0;
  localparam logic [1:0] SwUp   = 2'd1;
  localparam logic [1:0] SwDown = 2'd2;
  localparam logic [1:0] SwMid  = 2'd3;

  localparam logic [2:0] CmdWait   = 3'd0;
  localparam logic [2:0] CmdReset  = 3'd1;
  localparam logic [2:0] CmdAdjust = 3'd2;
  localparam logic [2:0] CmdToggle = 3'd3;
  localparam logic [2:0] CmdSweep  = 3'd4;
  localparam logic [2:0] CmdSingle = 3'd5;
  localparam logic [2:0] CmdBurst  = 3'd6;

  localparam logic [1:0] FlyWait = 2'd0;
  localparam logic [1:0] FlyOn   = 2'd1;
  localparam logic [1:0] FlyOff  = 2'd2;

  localparam logic [1:0] FeedHold = 2'd0;
  localparam logic [1:0] FeedLoad = 2'd1;
  localparam logic [1:0] FeedRun  = 2'd2;
  localparam logic [1:0] FeedJam  = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;     // load input word and run the decode/feeder step
    logic mod_start; // begin shot-count remainder
    logic finish;    // apply refire decision and fold target
  } sfjc_cmd_t;

  typedef struct packed {
    logic mod_done;
  } sfjc_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

/* rtl/sfjc_dp.sv */
// Datapath: command decode, flywheel, feeder states, shot remainder, target fold.
// Depends on sfjc_pkg.
`timescale 1ns / 1ps
module sfjc_dp import sfjc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sfjc_cmd_t          cmd,
  output sfjc_stat_t         stat,
  input  logic               link_online,
  input  logic [1:0]         left_switch,
  input  logic [1:0]         right_switch,
  input  logic signed [10:0] thumbwheel,
  input  logic signed [31:0] feeder_angle,
  input  logic signed [15:0] feeder_speed,
  input  logic               torque_stuck,
  input  logic [15:0]        angle_margin,
  input  logic [15:0]        stall_limit,
  input  logic [15:0]        back_off_angle,
  input  logic signed [16:0] load_step_angle,
  input  logic [15:0]        refire_period,
  output logic [2:0]         command,
  output logic [1:0]         flywheel_state,
  output logic [2:0]         flywheel_level,
  output logic [1:0]         feeder_state,
  output logic signed [31:0] target_angle
);
  logic prev_online;
  logic [1:0] startup_switch, prev_right_switch;
  logic signed [10:0] prev_wheel;
  logic [2:0] cmd_reg;
  logic [1:0] fly_state, feed_state;
  logic [2:0] fly_level;
  logic signed [31:0] angle_goal;
  logic [15:0] stall_count, shot_count;
  logic signed [31:0] angle;
  logic refire_pend;
  // shot remainder by restoring subtraction, one bit a cycle
  logic [15:0] rem;
  logic [4:0] mod_cnt;
  logic mod_busy;

  logic prev_online_next;
  logic [1:0] startup_switch_next, prev_right_switch_next;
  logic signed [10:0] prev_wheel_next;
  logic [2:0] cmd_reg_next, fly_level_next;
  logic [1:0] fly_state_next, feed_state_next;
  logic signed [31:0] angle_goal_next;
  logic [15:0] stall_count_next, shot_count_next;
  logic refire_next;

  logic signed [35:0] step_sum, back_sum, back_dif, lo_b, hi_b;
  logic still;
  logic [15:0] stall_inc;
  logic stall_trip;
  logic edge_r;
  logic [1:0] sw_start, sw_prev;

  always_comb begin
    step_sum = 36'(load_step_angle) + 36'(feeder_angle);
    back_sum = 36'({1'b0, back_off_angle}) + 36'(feeder_angle);
    back_dif = 36'(feeder_angle) - 36'({1'b0, back_off_angle});
    still = (feeder_speed > -16'sd5) && (feeder_speed < 16'sd5);
    stall_inc = (stall_count == 16'hFFFF) ? stall_count : stall_count + 16'd1;
    stall_trip = still && (stall_inc > stall_limit);

    prev_online_next = link_online;
    prev_right_switch_next = right_switch;
    sw_start = startup_switch;
    sw_prev = prev_right_switch;
    if (!prev_online && link_online) begin
      sw_start = right_switch;
      sw_prev = right_switch;
    end
    edge_r = sw_prev != right_switch;
    startup_switch_next = sw_start;
    cmd_reg_next = cmd_reg;
    fly_state_next = fly_state;
    fly_level_next = fly_level;
    feed_state_next = feed_state;
    angle_goal_next = angle_goal;
    stall_count_next = stall_count;
    shot_count_next = shot_count;
    prev_wheel_next = prev_wheel;
    refire_next = 1'b0;

    if (link_online) begin
      if (sw_start == right_switch) begin
        cmd_reg_next = CmdWait;
      end else begin
        startup_switch_next = SwNone;
        if (right_switch == SwMid) begin
          if (left_switch != SwNone) cmd_reg_next = CmdReset;
        end else if (left_switch == SwUp) begin
          if (right_switch == SwUp) cmd_reg_next = CmdAdjust;
          else if (right_switch == SwDown) cmd_reg_next = CmdToggle;
        end else if (left_switch == SwMid) begin
          if (right_switch == SwUp) begin
            cmd_reg_next = CmdSweep;
            if (edge_r) feed_state_next = FeedRun;
          end else if (right_switch == SwDown) begin
            cmd_reg_next = CmdReset;
          end
        end else if (left_switch == SwDown) begin
          if (right_switch == SwUp || right_switch == SwDown) begin
            cmd_reg_next = (right_switch == SwUp) ? CmdSingle : CmdBurst;
            if (edge_r) begin
              feed_state_next = FeedLoad;
              angle_goal_next = sat32(step_sum);
            end
          end
        end
      end
    end else begin
      cmd_reg_next = CmdWait;
      fly_state_next = FlyWait;
      feed_state_next = FeedHold;
    end

    if (cmd_reg_next == CmdToggle && edge_r) begin
      if (fly_state_next == FlyWait || fly_state_next == FlyOff) fly_state_next = FlyOn;
      else if (fly_state_next == FlyOn) fly_state_next = FlyOff;
    end
    if (cmd_reg_next == CmdAdjust) begin
      if (prev_wheel <= -11'sd600 && thumbwheel > -11'sd590) begin
        if (fly_level < 3'd4) fly_level_next = fly_level + 3'd1;
      end else if (prev_wheel >= 11'sd600 && thumbwheel < 11'sd590) begin
        if (fly_level > 3'd0) fly_level_next = fly_level - 3'd1;
      end
      prev_wheel_next = thumbwheel;
    end

    if (cmd_reg_next == CmdReset) feed_state_next = FeedHold;
    if (fly_state_next != FlyOn) feed_state_next = FeedHold;
    lo_b = 36'(angle_goal_next) + 36'({1'b0, angle_margin});
    hi_b = 36'(angle_goal_next) - 36'({1'b0, angle_margin});
    case (feed_state_next)
      FeedLoad: begin
        if (36'(feeder_angle) < lo_b) begin
          if (cmd_reg_next == CmdSingle) begin
            feed_state_next = FeedHold;
          end else if (cmd_reg_next == CmdBurst) begin
            shot_count_next = (shot_count + 16'd1 >= ShotWrap) ? 16'd0 : shot_count + 16'd1;
            refire_next = refire_period != 16'd0;
          end else if (cmd_reg_next == CmdSweep) begin
            feed_state_next = FeedRun;
          end
        end else begin
          stall_count_next = still ? (stall_trip ? 16'd0 : stall_inc) : 16'd0;
          if (stall_trip) begin
            feed_state_next = FeedJam;
            angle_goal_next = sat32(back_sum);
          end
        end
      end
      FeedRun: begin
        if (torque_stuck) begin
          feed_state_next = FeedJam;
          angle_goal_next = sat32(back_sum);
        end
      end
      FeedJam: begin
        if (36'(feeder_angle) > hi_b) begin
          angle_goal_next = sat32(step_sum);
          feed_state_next = FeedLoad;
        end else begin
          stall_count_next = still ? (stall_trip ? 16'd0 : stall_inc) : 16'd0;
          if (stall_trip) begin
            feed_state_next = FeedLoad;
            angle_goal_next = sat32(back_dif);
          end
        end
      end
      default: feed_state_next = FeedHold;
    endcase
  end

  // fold stage uses the registered goal after any refire update
  logic signed [31:0] goal_ref;
  logic signed [35:0] g, gd;
  always_comb begin
    goal_ref = (refire_pend && rem == 16'd0) ? sat32(36'(angle) + 36'(load_step_angle))
                                             : angle_goal;
    g = 36'(goal_ref);
    if (g < -36'sd92160) g = g + 36'(FullTurn);
    else if (g > 36'sd92160) g = g - 36'(FullTurn);
    gd = g - 36'(angle);
    if (gd > $signed(36'(HalfTurn))) g = g - 36'(FullTurn);
    else if (gd < -$signed(36'(HalfTurn))) g = g + 36'(FullTurn);
  end

  logic [16:0] trial;
  assign trial = {rem, shot_count[4'd15 - mod_cnt[3:0]]} - {1'b0, refire_period};
  assign stat.mod_done = mod_busy && mod_cnt == 5'd16;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_online <= 1'b0; startup_switch <= SwNone; prev_right_switch <= SwNone;
      prev_wheel <= '0; cmd_reg <= CmdWait; fly_state <= FlyWait; fly_level <= 3'd4;
      feed_state <= FeedHold; angle_goal <= '0; stall_count <= '0; shot_count <= '0;
      refire_pend <= 1'b0; mod_busy <= 1'b0; mod_cnt <= '0; rem <= '0;
      angle <= '0;
    end else begin
      if (cmd.start) begin
        prev_online <= prev_online_next; startup_switch <= startup_switch_next;
        prev_right_switch <= prev_right_switch_next; prev_wheel <= prev_wheel_next;
        cmd_reg <= cmd_reg_next; fly_state <= fly_state_next; fly_level <= fly_level_next;
        feed_state <= feed_state_next; angle_goal <= angle_goal_next;
        stall_count <= stall_count_next; shot_count <= shot_count_next;
        refire_pend <= refire_next; angle <= feeder_angle;
      end
      if (cmd.mod_start) begin
        mod_busy <= 1'b1; mod_cnt <= '0; rem <= '0;
      end else if (mod_busy && mod_cnt != 5'd16) begin
        mod_cnt <= mod_cnt + 5'd1;
        rem <= trial[16] ? {rem[14:0], shot_count[4'd15 - mod_cnt[3:0]]} : trial[15:0];
      end
      if (cmd.finish) begin
        mod_busy <= 1'b0;
        refire_pend <= 1'b0;
        if (feed_state == FeedLoad || feed_state == FeedJam) angle_goal <= sat32(g);
        else angle_goal <= goal_ref;
      end
    end
  end

  assign command = cmd_reg;
  assign flywheel_state = fly_state;
  assign flywheel_level = fly_level;
  assign feeder_state = feed_state;
  assign target_angle = angle_goal;
endmodule

/* rtl/sfjc_ctrl.sv */
// Sequencer: accepts a word, runs the step, remainder and fold, holds the result.
// Depends on sfjc_pkg.
`timescale 1ns / 1ps
module sfjc_ctrl import sfjc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output sfjc_cmd_t  cmd,
  input  sfjc_stat_t stat
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MOD = 4'b0010, S_WAIT = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.mod_done) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

/* rtl/shooter_feed_jam_controller.sv */
// Shooter feed and jam controller: top level with the configuration registers.
// Sequence: a word is accepted in S_IDLE, S_MOD starts the bit-serial shot-count
// remainder, S_WAIT applies the refire decision and fold once it is done, and S_OUT
// holds the result word valid until it is taken with no output stall. A new word is
// accepted only after the result has been taken; in_stall is high until then.
// Reset: synchronous, restores all registers and state to their power-on values.
// Depends on sfjc_pkg, sfjc_ctrl, sfjc_dp.
`timescale 1ns / 1ps
module shooter_feed_jam_controller import sfjc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                link_online,
  input  logic [1:0]          left_switch,
  input  logic [1:0]          right_switch,
  input  logic signed [10:0]  thumbwheel,
  input  logic signed [31:0]  feeder_angle,
  input  logic signed [15:0]  feeder_speed,
  input  logic                torque_stuck,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          command,
  output logic [1:0]          flywheel_state,
  output logic [2:0]          flywheel_level,
  output logic [1:0]          feeder_state,
  output logic signed [31:0]  target_angle
);
  logic [15:0] angle_margin, stall_limit, back_off_angle, refire_period;
  logic signed [16:0] load_step_angle;
  sfjc_cmd_t cmd;
  sfjc_stat_t stat;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_margin <= 16'd384; stall_limit <= 16'd50; back_off_angle <= 16'd11520;
      load_step_angle <= -17'sd11520; refire_period <= 16'd1000;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrMargin: angle_margin <= pwdata[15:0];
        AddrStall:  stall_limit <= pwdata[15:0];
        AddrBack:   back_off_angle <= pwdata[15:0];
        AddrStep:   load_step_angle <= pwdata[16:0];
        AddrPeriod: refire_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrMargin: prdata = {16'd0, angle_margin};
      AddrStall:  prdata = {16'd0, stall_limit};
      AddrBack:   prdata = {16'd0, back_off_angle};
      AddrStep:   prdata = 32'(load_step_angle);
      AddrPeriod: prdata = {16'd0, refire_period};
      default:    prdata = '0;
    endcase
  end

  sfjc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  sfjc_dp u_dp (
    .clk, .rst, .cmd, .stat, .link_online, .left_switch, .right_switch, .thumbwheel,
    .feeder_angle, .feeder_speed, .torque_stuck, .angle_margin, .stall_limit,
    .back_off_angle, .load_step_angle, .refire_period, .command, .flywheel_state,
    .flywheel_level, .feeder_state, .target_angle
  );
endmodule
